@@ rtl/core/elne_pkg.sv @@
// ----------------------------------------------------------------------------
// elne_pkg
// Shared types and constants of the EEG line noise extractor: field widths,
// request and register codes, scaling constants and the front/back structs.
// ----------------------------------------------------------------------------
`default_nettype none

package elne_pkg;

	// field widths
	localparam int unsigned REQ_W      = 2;
	localparam int unsigned CH_W       = 7;
	localparam int unsigned CODE_W     = 16;
	localparam int unsigned EV_W       = 8;
	localparam int unsigned UV_W       = 24;
	localparam int unsigned STIM_W     = 7;
	localparam int unsigned RESP_W     = 9;
	localparam int unsigned CC_W       = 8;
	localparam int unsigned WL_W       = 5;
	localparam int unsigned ZC_W       = 15;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 15;

	// request codes
	localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_STIM   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_RESP   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_CODE     = 2'd2;

	// configuration reset values
	localparam logic [CC_W-1:0] CC_RESET = 8'd16;
	localparam logic [WL_W-1:0] WL_RESET = 5'd5;
	localparam logic [ZC_W-1:0] ZC_RESET = 15'd2048;

	// event code mapping: response is byte - 0x30 + 127
	localparam logic [EV_W-1:0]   STIM_MASK   = 8'h7f;
	localparam logic [RESP_W-1:0] RESP_OFFSET = 9'd79;

	// scaling: 200 uV full scale, 8 fraction bits
	localparam int unsigned PROD_W    = 34;
	localparam logic signed [PROD_W-1:0] SCALE_MUL = 34'sd51200;

	// Q15.8 limits
	localparam logic signed [UV_W-1:0] Q_MAX = 24'sh7fffff;
	localparam logic signed [UV_W-1:0] Q_MIN = 24'sh800000;

	// shared divider geometry, two quotient bits per cycle
	localparam int unsigned DIV_NW    = 34;
	localparam int unsigned DIV_DW    = 16;
	localparam int unsigned DIV_STEPS = DIV_NW / 2;
	localparam int unsigned DIV_CW    = $clog2(DIV_STEPS + 1);

	// command queue between front and back
	localparam int unsigned CMDQ_DEPTH = 4;
	localparam int unsigned CMDQ_PW    = $clog2(CMDQ_DEPTH);

	typedef struct packed {
		logic [REQ_W-1:0]         kind;
		logic [CH_W-1:0]          ch;
		logic signed [CODE_W-1:0] code;
		logic [RESP_W-1:0]        ev;
	} cmd_t;

	typedef struct packed {
		logic avail;
		cmd_t cmd;
	} cmdq_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/elne_ram.sv @@
// ----------------------------------------------------------------------------
// elne_ram
// Generic simple dual port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module elne_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 2048,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/core/elne_div.sv @@
// ----------------------------------------------------------------------------
// elne_div
// Unsigned restoring divider, two quotient bits per cycle, shared by the
// sample scaling and the window mean.
// ----------------------------------------------------------------------------
`default_nettype none

module elne_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [elne_pkg::DIV_NW-1:0] num,
	input  wire logic [elne_pkg::DIV_DW-1:0] den,
	output logic                             busy,
	output logic      [elne_pkg::DIV_NW-1:0] quo
);

	localparam int unsigned NW = elne_pkg::DIV_NW;
	localparam int unsigned DW = elne_pkg::DIV_DW;

	logic            busy_q;
	logic [elne_pkg::DIV_CW-1:0] cnt_q;
	logic [DW-1:0]   rem_q;
	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   den_q;
	logic [DW-1:0]   rem_nxt;
	logic [NW-1:0]   quo_nxt;

	// two shift-subtract iterations per cycle
	always_comb begin
		logic [DW:0] t;
		rem_nxt = rem_q;
		quo_nxt = quo_q;
		for (int k = 0; k < 2; k++) begin
			t = {rem_nxt, quo_nxt[NW-1]};
			quo_nxt = {quo_nxt[NW-2:0], 1'b0};
			if (t >= {1'b0, den_q}) begin
				rem_nxt = DW'(t - {1'b0, den_q});
				quo_nxt[0] = 1'b1;
			end else begin
				rem_nxt = DW'(t);
			end
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == elne_pkg::DIV_CW'(elne_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

@@ rtl/core/elne_front.sv @@
// ----------------------------------------------------------------------------
// elne_front
// Input side: accepts request words, drops unknown requests and channels out
// of range, maps event bytes to codes and queues commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module elne_front #(
	parameter int unsigned MAX_CHANNELS = 128
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic [elne_pkg::REQ_W-1:0]          req_type,
	input  wire logic [elne_pkg::CH_W-1:0]           channel,
	input  wire logic signed [elne_pkg::CODE_W-1:0]  adc_code,
	input  wire logic [elne_pkg::EV_W-1:0]           event_byte,
	input  wire elne_pkg::back_ctl_t                 ctl,
	output elne_pkg::cmdq_t                          cmdq
);

	localparam logic [8:0] CH_LIMIT = 9'(MAX_CHANNELS);
	localparam int unsigned PW = elne_pkg::CMDQ_PW;

	elne_pkg::cmd_t     cmd_in;
	elne_pkg::cmd_t     mem_q [elne_pkg::CMDQ_DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [PW:0]        cnt_q;
	logic               keep;
	logic               enq;
	logic               deq;

	// classify the incoming word
	always_comb begin
		cmd_in.kind = req_type;
		cmd_in.ch   = channel;
		cmd_in.code = adc_code;
		if (req_type == elne_pkg::REQ_STIM) begin
			cmd_in.ev = elne_pkg::RESP_W'(event_byte & elne_pkg::STIM_MASK);
		end else begin
			cmd_in.ev = elne_pkg::RESP_W'(event_byte) + elne_pkg::RESP_OFFSET;
		end
		case (req_type)
			elne_pkg::REQ_SAMPLE: keep = (9'(channel) < CH_LIMIT);
			elne_pkg::REQ_STIM:   keep = 1'b1;
			elne_pkg::REQ_RESP:   keep = 1'b1;
			default:              keep = 1'b0;
		endcase
	end

	assign full = (cnt_q == (PW + 1)'(elne_pkg::CMDQ_DEPTH)) || ctl.clearing;
	assign enq  = push && !full && keep;
	assign deq  = ctl.pop;

	// command queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// command queue storage
	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	assign cmdq.avail = (cnt_q != '0);
	assign cmdq.cmd   = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

@@ rtl/core/elne_back.sv @@
// ----------------------------------------------------------------------------
// elne_back
// Execution side: event latches, sample scaling, window sum and mean over the
// per-channel history RAM, line component, frame slot and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module elne_back #(
	parameter int unsigned MAX_CHANNELS  = 128,
	parameter int unsigned HISTORY_DEPTH = 16,
	parameter int unsigned RING_SLOTS    = 1024,
	localparam int unsigned SLOT_W = $clog2(RING_SLOTS)
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire elne_pkg::cmdq_t                    cmdq,
	output elne_pkg::back_ctl_t                     ctl,
	input  wire logic [elne_pkg::CC_W-1:0]          channel_count,
	input  wire logic [elne_pkg::WL_W-1:0]          window_len,
	input  wire logic [elne_pkg::ZC_W-1:0]          zero_code,
	input  wire logic                               pop,
	output logic                                    res_valid,
	output logic [elne_pkg::CH_W-1:0]               out_channel,
	output logic [SLOT_W-1:0]                       slot,
	output logic signed [elne_pkg::UV_W-1:0]        sample_uv,
	output logic [SLOT_W-1:0]                       delayed_slot,
	output logic signed [elne_pkg::UV_W-1:0]        line_component_uv,
	output logic [elne_pkg::STIM_W-1:0]             stim_code,
	output logic [elne_pkg::RESP_W-1:0]             resp_code,
	output logic                                    frame_end
);

	localparam int unsigned MEM_DEPTH = MAX_CHANNELS * HISTORY_DEPTH;
	localparam int unsigned AW        = $clog2(MEM_DEPTH);
	localparam int unsigned PW        = $clog2(HISTORY_DEPTH);
	localparam int unsigned UV_W      = elne_pkg::UV_W;
	localparam int unsigned WL_W      = elne_pkg::WL_W;
	localparam int unsigned SUM_W     = UV_W + WL_W + 1;
	localparam int unsigned NW        = elne_pkg::DIV_NW;
	localparam int unsigned DW        = elne_pkg::DIV_DW;

	// sequencer states
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_SGO   = 3'd3;
	localparam logic [2:0] ST_SWAIT = 3'd4;
	localparam logic [2:0] ST_MGO   = 3'd5;
	localparam logic [2:0] ST_MWAIT = 3'd6;
	localparam logic [2:0] ST_WRITE = 3'd7;

	logic [2:0]                      state_q;
	logic [AW-1:0]                   clr_addr_q;
	logic [PW-1:0]                   pos_q;
	logic [SLOT_W-1:0]               fslot_q;
	logic [elne_pkg::STIM_W-1:0]     stim_q;
	logic [elne_pkg::RESP_W-1:0]     resp_q;
	logic                            rd_act_q;
	logic [WL_W-1:0]                 rd_cnt_q;
	logic                            rd_vld_s1;
	logic [WL_W-1:0]                 rd_idx_s1;
	logic                            res_vld_q;

	logic [elne_pkg::CH_W-1:0]       ch_q;
	logic signed [elne_pkg::CODE_W-1:0] code_q;
	logic signed [elne_pkg::PROD_W-1:0] prod_q;
	logic signed [UV_W-1:0]          val_q;
	logic signed [SUM_W-1:0]         sum_q;
	logic signed [UV_W-1:0]          dly_q;
	logic signed [UV_W-1:0]          line_q;

	logic [WL_W-1:0]                 w_eff;
	logic [WL_W-1:0]                 back_w;
	logic [8:0]                      cc_eff;
	logic [elne_pkg::ZC_W-1:0]       zero_eff;
	logic signed [16:0]              diff;
	logic [NW-1:0]                   prod_mag;
	logic [NW-1:0]                   sum_mag;
	logic                            div_start;
	logic [NW-1:0]                   div_num;
	logic [DW-1:0]                   div_den;
	logic                            div_busy;
	logic [NW-1:0]                   div_quo;
	logic signed [UV_W-1:0]          val_nxt;
	logic signed [UV_W:0]            mean;
	logic signed [UV_W:0]            line_full;
	logic signed [UV_W-1:0]          line_nxt;
	logic signed [UV_W-1:0]          dly_sel;
	logic [PW+1:0]                   rd_pos_t;
	logic [PW-1:0]                   rd_pos;
	logic [AW-1:0]                   raddr;
	logic [AW-1:0]                   waddr;
	logic                            we;
	logic [UV_W-1:0]                 wdata;
	logic [UV_W-1:0]                 rdata;
	logic                            can_load;
	logic                            fend;
	logic [SLOT_W:0]                 dslot_t;
	logic [SLOT_W-1:0]               dslot;
	logic                            take;

	// effective register values
	always_comb begin
		if (window_len == '0) begin
			w_eff = WL_W'(1);
		end else if (32'(window_len) > HISTORY_DEPTH) begin
			w_eff = WL_W'(HISTORY_DEPTH);
		end else begin
			w_eff = window_len;
		end
		back_w = w_eff >> 1;
		if (channel_count == '0) begin
			cc_eff = 9'd1;
		end else if (32'(channel_count) > MAX_CHANNELS) begin
			cc_eff = 9'(MAX_CHANNELS);
		end else begin
			cc_eff = 9'(channel_count);
		end
		zero_eff = (zero_code == '0) ? elne_pkg::ZC_W'(1) : zero_code;
	end

	// scaling operands
	assign diff     = 17'(code_q) - $signed({2'b00, zero_eff});
	assign prod_mag = (prod_q < 0) ? NW'(-prod_q) : NW'(prod_q);
	assign sum_mag  = (sum_q < 0) ? NW'(-sum_q) : NW'(sum_q);

	// shared divider operands
	assign div_start = (state_q == ST_SGO) || (state_q == ST_MGO);
	always_comb begin
		if (state_q == ST_SGO) begin
			div_num = (prod_mag << 1) + NW'(zero_eff);
			div_den = DW'({zero_eff, 1'b0});
		end else begin
			div_num = sum_mag;
			div_den = DW'(w_eff);
		end
	end

	elne_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// rounded scale result with saturation
	always_comb begin
		if (prod_q < 0) begin
			if (div_quo > NW'(34'd8388608)) begin
				val_nxt = elne_pkg::Q_MIN;
			end else begin
				val_nxt = UV_W'(-div_quo);
			end
		end else begin
			if (div_quo > NW'(34'd8388607)) begin
				val_nxt = elne_pkg::Q_MAX;
			end else begin
				val_nxt = UV_W'(div_quo);
			end
		end
	end

	// line component: delayed sample minus truncated mean
	always_comb begin
		mean      = (sum_q < 0) ? -(UV_W + 1)'(div_quo) : (UV_W + 1)'(div_quo);
		dly_sel   = (back_w == '0) ? val_q : dly_q;
		line_full = (UV_W + 1)'(dly_sel) - mean;
		if (line_full > (UV_W + 1)'(elne_pkg::Q_MAX)) begin
			line_nxt = elne_pkg::Q_MAX;
		end else if (line_full < (UV_W + 1)'(elne_pkg::Q_MIN)) begin
			line_nxt = elne_pkg::Q_MIN;
		end else begin
			line_nxt = UV_W'(line_full);
		end
	end

	// window read address: history position minus read index, wrapped
	always_comb begin
		rd_pos_t = (PW + 2)'(pos_q) + (PW + 2)'(HISTORY_DEPTH) - (PW + 2)'(rd_cnt_q);
		if (rd_pos_t >= (PW + 2)'(HISTORY_DEPTH)) begin
			rd_pos_t = rd_pos_t - (PW + 2)'(HISTORY_DEPTH);
		end
		rd_pos = PW'(rd_pos_t);
		raddr  = AW'(32'(ch_q) * HISTORY_DEPTH + 32'(rd_pos));
	end

	// history write port: clearing pass or new sample
	always_comb begin
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else begin
			we    = (state_q == ST_WRITE) && can_load;
			waddr = AW'(32'(ch_q) * HISTORY_DEPTH + 32'(pos_q));
			wdata = val_q;
		end
	end

	elne_ram #(
		.WIDTH (UV_W),
		.DEPTH (MEM_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// frame bookkeeping
	always_comb begin
		can_load = !res_vld_q || pop;
		fend     = (9'(ch_q) == cc_eff - 9'd1);
		dslot_t  = (SLOT_W + 1)'(fslot_q) + (SLOT_W + 1)'(RING_SLOTS) - (SLOT_W + 1)'(back_w);
		if (dslot_t >= (SLOT_W + 1)'(RING_SLOTS)) begin
			dslot_t = dslot_t - (SLOT_W + 1)'(RING_SLOTS);
		end
		dslot = SLOT_W'(dslot_t);
	end

	assign take         = (state_q == ST_IDLE) && cmdq.avail;
	assign ctl.pop      = take;
	assign ctl.clearing = (state_q == ST_CLEAR);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			pos_q      <= '0;
			fslot_q    <= '0;
			stim_q     <= '0;
			resp_q     <= '0;
			rd_act_q   <= 1'b0;
			rd_cnt_q   <= '0;
			rd_vld_s1  <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_act_q;
			if (rd_act_q) begin
				if (rd_cnt_q == w_eff) begin
					rd_act_q <= 1'b0;
				end else begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
				end
			end
			if (pop) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(MEM_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take) begin
						case (cmdq.cmd.kind)
							elne_pkg::REQ_STIM: stim_q <= elne_pkg::STIM_W'(cmdq.cmd.ev);
							elne_pkg::REQ_RESP: resp_q <= cmdq.cmd.ev;
							default:            state_q <= ST_MUL;
						endcase
					end
				end
				ST_MUL: begin
					rd_act_q <= 1'b1;
					rd_cnt_q <= WL_W'(1);
					state_q  <= ST_SGO;
				end
				ST_SGO: begin
					state_q <= ST_SWAIT;
				end
				ST_SWAIT: begin
					if (!div_busy && !rd_act_q && !rd_vld_s1) begin
						state_q <= ST_MGO;
					end
				end
				ST_MGO: begin
					state_q <= ST_MWAIT;
				end
				ST_MWAIT: begin
					if (!div_busy) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (can_load) begin
						res_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
						if (fend) begin
							stim_q  <= '0;
							resp_q  <= '0;
							fslot_q <= (fslot_q == SLOT_W'(RING_SLOTS - 1)) ?
								'0 : fslot_q + 1'b1;
							pos_q   <= (pos_q == PW'(HISTORY_DEPTH - 1)) ?
								'0 : pos_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// sample datapath
	always_ff @(posedge clk) begin
		if (take) begin
			ch_q   <= cmdq.cmd.ch;
			code_q <= cmdq.cmd.code;
		end
		if (state_q == ST_MUL) begin
			prod_q <= elne_pkg::PROD_W'(diff) * elne_pkg::SCALE_MUL;
			sum_q  <= '0;
		end else if (rd_vld_s1) begin
			sum_q <= sum_q + SUM_W'($signed(rdata));
		end
		if (rd_vld_s1 && (rd_idx_s1 == back_w)) begin
			dly_q <= $signed(rdata);
		end
		rd_idx_s1 <= rd_cnt_q;
		if ((state_q == ST_SWAIT) && !div_busy) begin
			val_q <= val_nxt;
		end
		if ((state_q == ST_MWAIT) && !div_busy) begin
			line_q <= line_nxt;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if ((state_q == ST_WRITE) && can_load) begin
			out_channel       <= ch_q;
			slot              <= fslot_q;
			sample_uv         <= val_q;
			delayed_slot      <= dslot;
			line_component_uv <= line_q;
			stim_code         <= fend ? stim_q : '0;
			resp_code         <= fend ? resp_q : '0;
			frame_end         <= fend;
		end
	end

	assign res_valid = res_vld_q;

endmodule

`default_nettype wire

@@ rtl/core/eeg_line_noise_extractor_unit.sv @@
// ----------------------------------------------------------------------------
// eeg_line_noise_extractor_unit
// Multichannel EEG frame builder with moving-average line noise extraction.
// ----------------------------------------------------------------------------
// After reset the history RAM is zeroed by a clearing pass over all
// MAX_CHANNELS * HISTORY_DEPTH entries (2048 at the defaults), during which
// full stays high; configuration writes are taken at any time. Event words
// only set a latch in the back end and give no result. A sample word takes
// the back end through pick-up, one multiply, then two runs of the shared
// divider at two quotient bits per cycle (each a start state and a wait state
// that runs the steps and takes the quotient; first the rounded microvolt
// scaling, then the window mean), with the window reads from the history RAM
// overlapping the first division, and a final write of history and result
// register once the result register is free. A four-word command queue
// decouples the input side, so new words are taken while a result waits to
// be popped. Configuration may only change while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module eeg_line_noise_extractor_unit #(
	parameter int unsigned MAX_CHANNELS  = 128,
	parameter int unsigned HISTORY_DEPTH = 16,
	parameter int unsigned RING_SLOTS    = 1024,
	localparam int unsigned SLOT_W = $clog2(RING_SLOTS)
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	// request words
	input  wire logic                                    push,
	output logic                                         full,
	input  wire logic [elne_pkg::REQ_W-1:0]              req_type,
	input  wire logic [elne_pkg::CH_W-1:0]               channel,
	input  wire logic signed [elne_pkg::CODE_W-1:0]      adc_code,
	input  wire logic [elne_pkg::EV_W-1:0]               event_byte,
	// result words
	output logic                                         empty,
	input  wire logic                                    pop,
	output logic [elne_pkg::CH_W-1:0]                    out_channel,
	output logic [SLOT_W-1:0]                            slot,
	output logic signed [elne_pkg::UV_W-1:0]             sample_uv,
	output logic [SLOT_W-1:0]                            delayed_slot,
	output logic signed [elne_pkg::UV_W-1:0]             line_component_uv,
	output logic [elne_pkg::STIM_W-1:0]                  stim_code,
	output logic [elne_pkg::RESP_W-1:0]                  resp_code,
	output logic                                         frame_end,
	// configuration writes
	input  wire logic                                    cfg_valid,
	output logic                                         cfg_ready,
	input  wire logic [elne_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [elne_pkg::CFG_DATA_W-1:0]         cfg_data
);

	logic [elne_pkg::CC_W-1:0] cc_q;
	logic [elne_pkg::WL_W-1:0] wl_q;
	logic [elne_pkg::ZC_W-1:0] zc_q;
	elne_pkg::cmdq_t           cmdq;
	elne_pkg::back_ctl_t       ctl;
	logic                      res_valid;
	logic                      pop_acc;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= elne_pkg::CC_RESET;
			wl_q <= elne_pkg::WL_RESET;
			zc_q <= elne_pkg::ZC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				elne_pkg::REG_CHANNEL_COUNT: cc_q <= cfg_data[elne_pkg::CC_W-1:0];
				elne_pkg::REG_WINDOW_LEN:    wl_q <= cfg_data[elne_pkg::WL_W-1:0];
				elne_pkg::REG_ZERO_CODE:     zc_q <= cfg_data[elne_pkg::ZC_W-1:0];
				default: ;
			endcase
		end
	end

	elne_front #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.channel    (channel),
		.adc_code   (adc_code),
		.event_byte (event_byte),
		.ctl        (ctl),
		.cmdq       (cmdq)
	);

	// result word leaves on pop while present
	assign pop_acc = pop && res_valid;
	assign empty   = !res_valid;

	elne_back #(
		.MAX_CHANNELS  (MAX_CHANNELS),
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.RING_SLOTS    (RING_SLOTS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmdq              (cmdq),
		.ctl               (ctl),
		.channel_count     (cc_q),
		.window_len        (wl_q),
		.zero_code         (zc_q),
		.pop               (pop_acc),
		.res_valid         (res_valid),
		.out_channel       (out_channel),
		.slot              (slot),
		.sample_uv         (sample_uv),
		.delayed_slot      (delayed_slot),
		.line_component_uv (line_component_uv),
		.stim_code         (stim_code),
		.resp_code         (resp_code),
		.frame_end         (frame_end)
	);

endmodule

`default_nettype wire

@@ rtl/core/elne_checker.sv @@
// ----------------------------------------------------------------------------
// elne_checker
// Port-level checks of the line noise extractor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module elne_checker #(
	parameter int unsigned SLOT_W = 10
) (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                full,
	input wire logic                                empty,
	input wire logic                                pop,
	input wire logic [elne_pkg::CH_W-1:0]           out_channel,
	input wire logic [SLOT_W-1:0]                   slot,
	input wire logic signed [elne_pkg::UV_W-1:0]    sample_uv,
	input wire logic [elne_pkg::STIM_W-1:0]         stim_code,
	input wire logic [elne_pkg::RESP_W-1:0]         resp_code,
	input wire logic                                frame_end
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(slot) && $stable(sample_uv)
			&& $stable(out_channel)))
	else $error("result word changed while stalled");

	// event codes only show on the last channel of a frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !frame_end) |-> (stim_code == '0 && resp_code == '0))
	else $error("event code outside frame end");

	// a response code is either cleared or offset by the mapping
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_end) |-> (resp_code == '0 || resp_code >= 9'd79))
	else $error("response code out of mapping range");

	// a frame end advances the slot before the next word
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && frame_end) |=> (empty || slot != $past(slot)))
	else $error("slot not advanced after frame end");

	// history clearing holds off input right after reset
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> full)
	else $error("input taken during clearing pass");

endmodule

bind eeg_line_noise_extractor_unit elne_checker #(
	.SLOT_W ($clog2(RING_SLOTS))
) u_elne_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.full        (full),
	.empty       (empty),
	.pop         (pop),
	.out_channel (out_channel),
	.slot        (slot),
	.sample_uv   (sample_uv),
	.stim_code   (stim_code),
	.resp_code   (resp_code),
	.frame_end   (frame_end)
);

`default_nettype wire

@@ sim/elne_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elne_result_checker
// Passive checker for the EEG line noise extractor. It follows the request,
// result and register channels, predicts each result word from its own copy
// of the history, latches and registers, and compares every popped word field
// by field with the oldest prediction.
// ----------------------------------------------------------------------------
module elne_result_checker #(
	parameter int unsigned MAX_CHANNELS  = 128,
	parameter int unsigned HISTORY_DEPTH = 16,
	parameter int unsigned RING_SLOTS    = 1024,
	localparam int unsigned SLOT_W = $clog2(RING_SLOTS)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	input  logic                                   full,
	input  logic [elne_pkg::REQ_W-1:0]             req_type,
	input  logic [elne_pkg::CH_W-1:0]              channel,
	input  logic signed [elne_pkg::CODE_W-1:0]     adc_code,
	input  logic [elne_pkg::EV_W-1:0]              event_byte,
	input  logic                                   empty,
	input  logic                                   pop,
	input  logic [elne_pkg::CH_W-1:0]              out_channel,
	input  logic [SLOT_W-1:0]                      slot,
	input  logic signed [elne_pkg::UV_W-1:0]       sample_uv,
	input  logic [SLOT_W-1:0]                      delayed_slot,
	input  logic signed [elne_pkg::UV_W-1:0]       line_component_uv,
	input  logic [elne_pkg::STIM_W-1:0]            stim_code,
	input  logic [elne_pkg::RESP_W-1:0]            resp_code,
	input  logic                                   frame_end,
	input  logic                                   cfg_valid,
	input  logic                                   cfg_ready,
	input  logic [elne_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [elne_pkg::CFG_DATA_W-1:0]        cfg_data,
	output int                                     errors,
	output int                                     pending
);
	import elne_pkg::*;

	typedef struct packed {
		logic [CH_W-1:0]        ch;
		logic [SLOT_W-1:0]      slot;
		logic signed [UV_W-1:0] uv;
		logic [SLOT_W-1:0]      dslot;
		logic signed [UV_W-1:0] line;
		logic [STIM_W-1:0]      stim;
		logic [RESP_W-1:0]      resp;
		logic                   fend;
	} result_word_t;

	// predicted words still waiting to be popped
	result_word_t expected_words[$];

	// shadow state of the block
	logic signed [UV_W-1:0] history [MAX_CHANNELS*HISTORY_DEPTH];
	logic [SLOT_W-1:0]      frame_slot;
	logic [STIM_W-1:0]      stim_latch;
	logic [RESP_W-1:0]      resp_latch;
	int                     hist_pos;

	// shadow registers
	logic [CC_W-1:0] reg_cc;
	logic [WL_W-1:0] reg_wl;
	logic [ZC_W-1:0] reg_zc;

	function automatic logic signed [UV_W-1:0] sat_q15_8(input longint v);
		if (v > longint'(Q_MAX))
			return Q_MAX;
		if (v < longint'(Q_MIN))
			return Q_MIN;
		return UV_W'(v);
	endfunction

	function automatic int field_diff(input string name, input longint want, input longint got);
		if (want == got)
			return 0;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		return 1;
	endfunction

	// scale one sample, run the window mean and queue the predicted word
	task automatic extract_line_noise(input logic [CH_W-1:0] ch,
		input logic signed [CODE_W-1:0] code_in);
		int cc_eff;
		int w;
		int back;
		int base;
		longint zero;
		longint num;
		longint mag;
		longint q;
		longint sum;
		longint mean;
		logic signed [UV_W-1:0] val;
		logic signed [UV_W-1:0] delayed;
		result_word_t r;

		cc_eff = (reg_cc == 0) ? 1 : ((reg_cc > MAX_CHANNELS) ? MAX_CHANNELS : reg_cc);
		w = (reg_wl == 0) ? 1 : ((reg_wl > HISTORY_DEPTH) ? HISTORY_DEPTH : reg_wl);
		zero = (reg_zc == 0) ? 1 : longint'(reg_zc);

		// rounded microvolts, half away from zero
		num = (longint'(code_in) - zero) * longint'(SCALE_MUL);
		mag = (num < 0) ? -num : num;
		q = (2 * mag + zero) / (2 * zero);
		val = sat_q15_8((num < 0) ? -q : q);

		// mean of the previous w samples of this channel, truncated
		base = ch * HISTORY_DEPTH;
		sum = 0;
		for (int i = 1; i <= w; i++)
			sum += longint'(history[base + (hist_pos + HISTORY_DEPTH - i) % HISTORY_DEPTH]);
		mean = sum / longint'(w);

		back = w / 2;
		if (back == 0)
			delayed = val;
		else
			delayed = history[base + (hist_pos + HISTORY_DEPTH - back) % HISTORY_DEPTH];

		history[base + hist_pos] = val;

		r.ch    = ch;
		r.slot  = frame_slot;
		r.uv    = val;
		r.dslot = frame_slot - SLOT_W'(back);
		r.line  = sat_q15_8(longint'(delayed) - mean);
		r.fend  = (int'(ch) == cc_eff - 1);
		r.stim  = r.fend ? stim_latch : '0;
		r.resp  = r.fend ? resp_latch : '0;
		expected_words.push_back(r);

		// frame end reports the latches once and moves to the next slot
		if (r.fend) begin
			stim_latch = '0;
			resp_latch = '0;
			frame_slot = frame_slot + 1'b1;
			hist_pos = (hist_pos + 1) % HISTORY_DEPTH;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_word_t want;
		int bad;

		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS * HISTORY_DEPTH; i++)
				history[i] = '0;
			frame_slot = '0;
			stim_latch = '0;
			resp_latch = '0;
			hist_pos = 0;
			reg_cc = CC_RESET;
			reg_wl = WL_RESET;
			reg_zc = ZC_RESET;
			expected_words.delete();
			errors = 0;
			pending = 0;
		end else begin
			// result word leaves the block
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word, expected none, actual channel %0d",
						$time, out_channel);
				end else begin
					want = expected_words.pop_front();
					bad = 0;
					bad += field_diff("out_channel", want.ch, out_channel);
					bad += field_diff("slot", want.slot, slot);
					bad += field_diff("sample_uv", want.uv, sample_uv);
					bad += field_diff("delayed_slot", want.dslot, delayed_slot);
					bad += field_diff("line_component_uv", want.line, line_component_uv);
					bad += field_diff("stim_code", want.stim, stim_code);
					bad += field_diff("resp_code", want.resp, resp_code);
					bad += field_diff("frame_end", want.fend, frame_end);
					if (bad != 0)
						errors++;
				end
			end

			// request word enters the block
			if (push && !full) begin
				case (req_type)
					REQ_STIM: begin
						stim_latch = STIM_W'(event_byte & STIM_MASK);
					end
					REQ_RESP: begin
						resp_latch = RESP_W'(event_byte) + RESP_OFFSET;
					end
					REQ_SAMPLE: begin
						if (channel < MAX_CHANNELS)
							extract_line_noise(channel, adc_code);
					end
					default: begin
					end
				endcase
			end

			// register write
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CHANNEL_COUNT: reg_cc = cfg_data[CC_W-1:0];
					REG_WINDOW_LEN:    reg_wl = cfg_data[WL_W-1:0];
					REG_ZERO_CODE:     reg_zc = cfg_data[ZC_W-1:0];
					default: begin
					end
				endcase
			end

			pending = expected_words.size();
		end
	end

endmodule

@@ sim/eeg_line_noise_extractor_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eeg_line_noise_extractor_unit_test
// Stimulus and verdict for the EEG line noise extractor. A short directed run
// under the reset settings is followed by phases of frames with random codes
// and events, each phase under its own register settings and idling pattern.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module eeg_line_noise_extractor_unit_test;
	import elne_pkg::*;

	localparam int unsigned MAX_CHANNELS  = 128;
	localparam int unsigned HISTORY_DEPTH = 16;
	localparam int unsigned RING_SLOTS    = 1024;
	localparam int unsigned SLOT_W        = $clog2(RING_SLOTS);
	localparam int          DRAIN_CYCLES  = 64;
	localparam int          CYCLE_LIMIT   = 500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     push = 1'b0;
	logic                     full;
	logic [REQ_W-1:0]         req_type = '0;
	logic [CH_W-1:0]          channel = '0;
	logic signed [CODE_W-1:0] adc_code = '0;
	logic [EV_W-1:0]          event_byte = '0;

	logic                     empty;
	logic                     pop = 1'b0;
	logic [CH_W-1:0]          out_channel;
	logic [SLOT_W-1:0]        slot;
	logic signed [UV_W-1:0]   sample_uv;
	logic [SLOT_W-1:0]        delayed_slot;
	logic signed [UV_W-1:0]   line_component_uv;
	logic [STIM_W-1:0]        stim_code;
	logic [RESP_W-1:0]        resp_code;
	logic                     frame_end;

	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;

	int errors;
	int pending;
	int tx_idle = 0;
	int rx_stall = 0;
	int cycle_count = 0;
	int cur_cc = CC_RESET;
	int cur_zc = ZC_RESET;

	eeg_line_noise_extractor_unit #(
		.MAX_CHANNELS  (MAX_CHANNELS),
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.RING_SLOTS    (RING_SLOTS)
	) DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.req_type          (req_type),
		.channel           (channel),
		.adc_code          (adc_code),
		.event_byte        (event_byte),
		.empty             (empty),
		.pop               (pop),
		.out_channel       (out_channel),
		.slot              (slot),
		.sample_uv         (sample_uv),
		.delayed_slot      (delayed_slot),
		.line_component_uv (line_component_uv),
		.stim_code         (stim_code),
		.resp_code         (resp_code),
		.frame_end         (frame_end),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	elne_result_checker #(
		.MAX_CHANNELS  (MAX_CHANNELS),
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.RING_SLOTS    (RING_SLOTS)
	) u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.req_type          (req_type),
		.channel           (channel),
		.adc_code          (adc_code),
		.event_byte        (event_byte),
		.empty             (empty),
		.pop               (pop),
		.out_channel       (out_channel),
		.slot              (slot),
		.sample_uv         (sample_uv),
		.delayed_slot      (delayed_slot),
		.line_component_uv (line_component_uv),
		.stim_code         (stim_code),
		.resp_code         (resp_code),
		.frame_end         (frame_end),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.errors            (errors),
		.pending           (pending)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side stalls
	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= rx_stall);
	end

	function automatic int idle_gap();
		int g;
		g = 0;
		while (g < 40 && $urandom_range(99) < tx_idle)
			g++;
		return g;
	endfunction

	// mostly full-range codes, some close to the zero code for rounding cases
	function automatic logic signed [CODE_W-1:0] pick_code();
		if ($urandom_range(3) == 0)
			return CODE_W'(cur_zc + $urandom_range(64) - 32);
		return CODE_W'($urandom);
	endfunction

	// one request word; push stays high afterwards for a back-to-back word
	task automatic send_word(input logic [REQ_W-1:0] req, input logic [CH_W-1:0] ch,
		input logic signed [CODE_W-1:0] code, input logic [EV_W-1:0] ev);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push       <= 1'b1;
		req_type   <= req;
		channel    <= ch;
		adc_code   <= code;
		event_byte <= ev;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic send_sample(input logic [CH_W-1:0] ch, input logic signed [CODE_W-1:0] code);
		send_word(REQ_SAMPLE, ch, code, EV_W'($urandom));
	endtask

	task automatic send_event(input logic [REQ_W-1:0] req, input logic [EV_W-1:0] ev);
		send_word(req, CH_W'($urandom), CODE_W'($urandom), ev);
	endtask

	// wait for every result word, then for any event word still in flight
	task automatic settle();
		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// write all three registers, unused upper data bits random
	task automatic program_regs(input logic [CC_W-1:0] cc, input logic [WL_W-1:0] wl,
		input logic [ZC_W-1:0] zc);
		logic [CFG_IDX_W-1:0]  idx [3];
		logic [CFG_DATA_W-1:0] val [3];
		idx[0] = REG_CHANNEL_COUNT;
		idx[1] = REG_WINDOW_LEN;
		idx[2] = REG_ZERO_CODE;
		val[0] = {(CFG_DATA_W-CC_W)'($urandom), cc};
		val[1] = {(CFG_DATA_W-WL_W)'($urandom), wl};
		val[2] = zc;
		cfg_valid <= 1'b1;
		for (int i = 0; i < 3; i++) begin
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		cur_cc = (cc == 0) ? 1 : ((cc > MAX_CHANNELS) ? MAX_CHANNELS : cc);
		cur_zc = zc;
	endtask

	// frames in channel order with events mixed in, plus some noise words
	task automatic send_frames(input int n_items);
		int sent;
		logic [REQ_W-1:0] req;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				req = REQ_W'($urandom);
				send_word(req, CH_W'($urandom), CODE_W'($urandom), EV_W'($urandom));
				if (req == REQ_SAMPLE || req == REQ_STIM || req == REQ_RESP)
					sent++;
			end else begin
				for (int c = 0; c < cur_cc; c++) begin
					if ($urandom_range(7) == 0) begin
						send_event($urandom_range(1) ? REQ_STIM : REQ_RESP, EV_W'($urandom));
						sent++;
					end
					if (cur_cc <= 16 || c == cur_cc - 1 || $urandom_range(7) == 0) begin
						send_sample(CH_W'(c), pick_code());
						sent++;
					end
				end
			end
		end
	endtask

	task automatic run_phase(input logic [CC_W-1:0] cc, input logic [WL_W-1:0] wl,
		input logic [ZC_W-1:0] zc, input int tx, input int rx, input int n_items);
		settle();
		program_regs(cc, wl, zc);
		tx_idle = tx;
		rx_stall = rx;
		send_frames(n_items);
	endtask

	initial begin : stimulus
		int tx;
		int rx;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words under the reset settings
		send_sample(7'd0, CODE_W'(ZC_RESET));
		send_event(REQ_STIM, 8'hff);
		send_event(REQ_RESP, 8'hff);
		send_sample(7'd15, 16'sh7fff);
		send_sample(7'd15, 16'sh8000);
		send_event(REQ_RESP, 8'h00);
		send_event(REQ_STIM, 8'h80);
		send_sample(7'd127, 16'sh0000);
		send_word(2'd3, 7'd15, 16'sh1234, 8'h5a);
		send_sample(7'd15, 16'sd2049);
		send_sample(7'd15, 16'sd2047);
		send_event(REQ_STIM, 8'h55);
		send_event(REQ_RESP, 8'haa);
		send_sample(7'd14, 16'sd1000);
		send_sample(7'd15, -16'sd1000);
		send_sample(7'd15, 16'sd5000);
		send_sample(7'd15, 16'sd16000);
		send_sample(7'd15, -16'sd16000);
		send_sample(7'd0, 16'sh7fff);

		// register extremes and out-of-range values
		run_phase(8'd1, 5'd1, 15'd1, 0, 0, 150);
		run_phase(8'd128, 5'd16, 15'd32767, 78, 0, 200);
		run_phase(8'd0, 5'd0, 15'd0, 0, 78, 100);
		run_phase(8'd255, 5'd31, 15'd2048, 23, 23, 100);

		// random settings, small frames
		for (int p = 0; p < 5; p++) begin
			case (p % 4)
				0: begin tx = 0;  rx = 0;  end
				1: begin tx = 78; rx = 0;  end
				2: begin tx = 0;  rx = 78; end
				default: begin tx = 23; rx = 23; end
			endcase
			run_phase(CC_W'($urandom_range(1, 8)), WL_W'($urandom),
				($urandom_range(3) == 0) ? ZC_W'($urandom_range(16)) : ZC_W'($urandom),
				tx, rx, 150);
		end

		// drain and verdict
		rx_stall = 0;
		settle();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/elne_pkg.sv
rtl/core/elne_ram.sv
rtl/core/elne_div.sv
rtl/core/elne_front.sv
rtl/core/elne_back.sv
rtl/core/eeg_line_noise_extractor_unit.sv
rtl/core/elne_checker.sv
sim/elne_result_checker.sv
sim/eeg_line_noise_extractor_unit_test.sv
